FILE: rtl/srbag_pkg.sv
// ----------------------------------------------------------------------------
// srbag_pkg: shared definitions for the swap-remove random bag
// Action and status codes, field widths, default sizes and the controller
// state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srbag_pkg;

  // default sizes
  localparam int DEPTH_DEF       = 1024;
  localparam int VALUE_WIDTH_DEF = 32;

  // fixed field widths
  localparam int ACT_W   = 2;
  localparam int VAL_W   = 32;
  localparam int SEED_W  = 64;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 11;

  // action codes
  localparam logic [ACT_W-1:0] ACT_ADD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DEL = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SEL = 2'd2;
  localparam logic [ACT_W-1:0] ACT_CLR = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_RDW,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/srbag_div.sv
// ----------------------------------------------------------------------------
// srbag_div: iterative seed modulo count
// Restoring division, one dividend bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srbag_div #(
  parameter int CW = 11
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [srbag_pkg::SEED_W-1:0] dividend,
  input  wire logic [CW-1:0]              divisor,
  output logic                            done,
  output logic [CW-1:0]                   remainder
);

  localparam int STEP_W = $clog2(srbag_pkg::SEED_W);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [STEP_W-1:0]            step_r, step_nxt;
  logic [srbag_pkg::SEED_W-1:0] quo_r, quo_nxt;
  logic [CW-1:0]                rem_r, rem_nxt;
  logic [CW-1:0]                den_r, den_nxt;
  logic [CW:0]                  trial;

  // one shift-subtract step per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    trial    = {rem_r, quo_r[srbag_pkg::SEED_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[srbag_pkg::SEED_W-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = CW'(trial - {1'b0, den_r});
      end else begin
        rem_nxt = trial[CW-1:0];
      end
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(srbag_pkg::SEED_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

FILE: rtl/srbag_mem.sv
// ----------------------------------------------------------------------------
// srbag_mem: entry table
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srbag_mem #(
  parameter int DEPTH = 1024,
  parameter int SW    = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [SW-1:0]            wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [SW-1:0]                 rdata
);

  logic [SW-1:0] mem [DEPTH];
  logic [SW-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/swap_remove_random_bag_unit.sv
// ----------------------------------------------------------------------------
// swap_remove_random_bag_unit: unordered bag with random sampling
// Top level: controller, count register, entry table, modulo unit and the
// result register.
// ----------------------------------------------------------------------------
// Usage:
//   One beat on the in_ channel carries one action (add, delete at seed,
//   select at seed, clear); each action gives exactly one beat on the out_
//   channel with status, picked value and the count after the action.
//   Items are handled one at a time: in_tready is high only while the
//   controller is idle.
//   Add, clear and any action on an empty bag pass through the execute and
//   done states to the result register; a delete or select on a non-empty
//   bag also runs the 64 steps of the bit-serial modulo unit and then the
//   registered table read.
//   The result register lets the next beat be accepted while a result still
//   waits; if the receiver stalls longer, the next result waits in the
//   controller and no further beat is accepted until it is moved out.
//   Reset empties the bag (count zero) and drops any pending result; table
//   contents are not cleared, since only slots below the count are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swap_remove_random_bag_unit #(
  parameter int DEPTH       = srbag_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = srbag_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [95:0] in_tdata,   // item_value [31:0], seed [95:32]
  input  wire logic [1:0]  in_tuser,   // action [1:0]
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // picked_value [31:0], entry_count [42:32]
  output logic [1:0]       out_tuser   // status [1:0]
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = (VALUE_WIDTH < srbag_pkg::VAL_W) ? VALUE_WIDTH : srbag_pkg::VAL_W;

  srbag_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]                    count_r, count_nxt;
  logic [srbag_pkg::ACT_W-1:0]      act_r;
  logic [SW-1:0]                    val_r;
  logic [srbag_pkg::SEED_W-1:0]     seed_r;
  logic [AW-1:0]                    slot_r, slot_nxt;
  logic [srbag_pkg::STAT_W-1:0]     res_status_r, res_status_nxt;
  logic [srbag_pkg::VAL_W-1:0]      res_picked_r, res_picked_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic [srbag_pkg::STAT_W-1:0]     out_status_r;
  logic [srbag_pkg::VAL_W-1:0]      out_picked_r;
  logic [srbag_pkg::CNT_W-1:0]      out_count_r;
  logic                             out_load;

  logic                             in_fire;
  logic                             div_start, div_done;
  logic [CW-1:0]                    div_rem;
  logic                             mem_we, mem_re;
  logic [AW-1:0]                    mem_waddr, mem_raddr;
  logic [SW-1:0]                    mem_wdata, mem_rdata;

  assign in_tready = (state_r == srbag_pkg::S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // modulo unit
  srbag_div #(
    .CW (CW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (seed_r),
    .divisor   (count_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  // entry table
  srbag_mem #(
    .DEPTH (DEPTH),
    .SW    (SW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // controller: next state, count update and table accesses
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    slot_nxt       = slot_r;
    res_status_nxt = res_status_r;
    res_picked_nxt = res_picked_r;
    div_start      = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = count_r[AW-1:0];
    mem_wdata      = val_r;
    mem_re         = 1'b0;
    mem_raddr      = div_rem[AW-1:0];
    out_load       = 1'b0;
    unique case (state_r)
      srbag_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = srbag_pkg::S_EXEC;
        end
      end
      srbag_pkg::S_EXEC: begin
        res_status_nxt = srbag_pkg::ST_OK;
        res_picked_nxt = '0;
        state_nxt      = srbag_pkg::S_DONE;
        unique case (act_r)
          srbag_pkg::ACT_ADD: begin
            if (count_r >= CW'(DEPTH)) begin
              res_status_nxt = srbag_pkg::ST_FULL;
            end else begin
              mem_we    = 1'b1;
              count_nxt = count_r + CW'(1);
            end
          end
          srbag_pkg::ACT_DEL, srbag_pkg::ACT_SEL: begin
            if (count_r == '0) begin
              res_status_nxt = srbag_pkg::ST_EMPTY;
            end else begin
              div_start = 1'b1;
              state_nxt = srbag_pkg::S_DIV;
            end
          end
          srbag_pkg::ACT_CLR: begin
            count_nxt = '0;
          end
          default: begin
            count_nxt = count_r;
          end
        endcase
      end
      srbag_pkg::S_DIV: begin
        // delete fetches the last entry, select fetches the chosen slot
        if (div_done) begin
          slot_nxt = div_rem[AW-1:0];
          mem_re   = 1'b1;
          if (act_r == srbag_pkg::ACT_DEL) begin
            mem_raddr = AW'(count_r - CW'(1));
          end
          state_nxt = srbag_pkg::S_RDW;
        end
      end
      srbag_pkg::S_RDW: begin
        if (act_r == srbag_pkg::ACT_DEL) begin
          mem_we    = 1'b1;
          mem_waddr = slot_r;
          mem_wdata = mem_rdata;
          count_nxt = count_r - CW'(1);
        end else begin
          res_picked_nxt = srbag_pkg::VAL_W'(mem_rdata);
        end
        state_nxt = srbag_pkg::S_DONE;
      end
      srbag_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = srbag_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = srbag_pkg::S_IDLE;
      end
    endcase
  end

  // result register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srbag_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item capture and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r  <= in_tuser;
      val_r  <= in_tdata[SW-1:0];
      seed_r <= in_tdata[95:32];
    end
    slot_r       <= slot_nxt;
    res_status_r <= res_status_nxt;
    res_picked_r <= res_picked_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_picked_r <= res_picked_r;
      out_count_r  <= srbag_pkg::CNT_W'(count_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {5'd0, out_count_r, out_picked_r};

  // count never passes the table depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("bag count above depth");

  // the modulo result always names a live slot
  a_rem_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == srbag_pkg::S_DIV && div_done) |-> (div_rem < count_r))
    else $error("modulo result outside the bag");

  // table writes happen only in the execute and write-back steps
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == srbag_pkg::S_EXEC || state_r == srbag_pkg::S_RDW))
    else $error("table write outside an update step");

  // a new item is taken only after the previous result left the controller
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == srbag_pkg::S_EXEC && !out_load))
    else $error("item accepted while another is in progress");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the swap-remove random bag
// Streams add, delete, select and clear actions into the bag and checks
// every result beat against an in-bench model of the table and its count.
// The run has a short directed part, then a fill up to full capacity, then
// random bursts that grow, shrink or hold the bag. Handshake idling changes
// over the run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int RAND_OPS   = 293;
  localparam int STALL_MAX  = 5000;
  localparam int TAIL_WAIT  = 100;

  typedef struct {
    logic [srbag_pkg::ACT_W-1:0]  action;
    logic [srbag_pkg::VAL_W-1:0]  value;
    logic [srbag_pkg::SEED_W-1:0] seed;
    bit                           drain;
  } bag_op_t;

  typedef struct {
    logic [srbag_pkg::STAT_W-1:0] status;
    logic [srbag_pkg::VAL_W-1:0]  picked;
    logic [srbag_pkg::CNT_W-1:0]  count;
  } bag_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata   = '0;   // item_value [31:0], seed [95:32]
  logic [1:0]  in_tuser   = '0;   // action [1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;         // picked_value [31:0], entry_count [42:32]
  logic [1:0]  out_tuser;         // status [1:0]

  // pending actions and results still owed by the bag
  bag_op_t     op_q[$];
  bag_result_t expected_q[$];

  // model of the bag
  logic [srbag_pkg::VAL_W-1:0] bag_mem [srbag_pkg::DEPTH_DEF];
  int unsigned                 bag_count = 0;

  // count seen by the generator while building the action list
  int unsigned gen_count = 0;

  int total_ops    = 1;
  int accepted_ops = 0;
  int phase        = 0;
  int err_count    = 0;
  int idle_cycles  = 0;
  int n_add = 0, n_del = 0, n_sel = 0, n_clr = 0;
  int n_empty = 0, n_full = 0, peak_count = 0;

  swap_remove_random_bag_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  // apply one action to the model and return the result it owes
  function automatic bag_result_t bag_apply(logic [srbag_pkg::ACT_W-1:0] action,
                                            logic [srbag_pkg::VAL_W-1:0] value,
                                            logic [srbag_pkg::SEED_W-1:0] seed);
    bag_result_t     r;
    longint unsigned cnt64;
    int unsigned     slot;
    r.status = srbag_pkg::ST_OK;
    r.picked = '0;
    cnt64    = bag_count;
    case (action)
      srbag_pkg::ACT_ADD: begin
        if (bag_count >= srbag_pkg::DEPTH_DEF) begin
          r.status = srbag_pkg::ST_FULL;
        end else begin
          bag_mem[bag_count] = value;
          bag_count++;
        end
      end
      srbag_pkg::ACT_DEL: begin
        if (bag_count == 0) begin
          r.status = srbag_pkg::ST_EMPTY;
        end else begin
          slot = int'(seed % cnt64);
          bag_mem[slot] = bag_mem[bag_count-1];
          bag_count--;
        end
      end
      srbag_pkg::ACT_SEL: begin
        if (bag_count == 0) begin
          r.status = srbag_pkg::ST_EMPTY;
        end else begin
          slot     = int'(seed % cnt64);
          r.picked = bag_mem[slot];
        end
      end
      default: bag_count = 0;
    endcase
    r.count = bag_count[srbag_pkg::CNT_W-1:0];
    return r;
  endfunction

  // seeds that hit the edges of the modulo as well as random ones
  function automatic logic [srbag_pkg::SEED_W-1:0] rand_seed(int unsigned cnt);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return (cnt == 0) ? '0 : srbag_pkg::SEED_W'(cnt - 1);
      3:       return srbag_pkg::SEED_W'(cnt);
      4:       return srbag_pkg::SEED_W'($urandom_range(0, 2047));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic logic [srbag_pkg::VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_op(logic [srbag_pkg::ACT_W-1:0] action,
                          logic [srbag_pkg::VAL_W-1:0] value,
                          logic [srbag_pkg::SEED_W-1:0] seed, bit drain);
    bag_op_t op;
    op.action = action;
    op.value  = value;
    op.seed   = seed;
    op.drain  = drain;
    op_q.push_back(op);
    case (action)
      srbag_pkg::ACT_ADD: if (gen_count < srbag_pkg::DEPTH_DEF) gen_count++;
      srbag_pkg::ACT_DEL: if (gen_count > 0) gen_count--;
      srbag_pkg::ACT_SEL: ;
      default: gen_count = 0;
    endcase
  endtask

  // input driver: predicts on each accepted beat, then loads the next one
  always @(posedge clk) begin : drive_actions
    bag_result_t r;
    bag_op_t     nxt;
    int          tx_idle;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        r = bag_apply(in_tuser, in_tdata[31:0], in_tdata[95:32]);
        expected_q.push_back(r);
        accepted_ops++;
        case (in_tuser)
          srbag_pkg::ACT_ADD: n_add++;
          srbag_pkg::ACT_DEL: n_del++;
          srbag_pkg::ACT_SEL: n_sel++;
          default: n_clr++;
        endcase
      end
      phase   <= (accepted_ops * 3 / total_ops > 2) ? 2 : accepted_ops * 3 / total_ops;
      tx_idle = (phase == 0) ? 37 : (phase == 1) ? 61 : 0;
      if (!in_tvalid || in_tready) begin
        if (op_q.size() != 0 && $urandom_range(0, 99) >= tx_idle &&
            (!op_q[0].drain || expected_q.size() == 0)) begin
          nxt = op_q.pop_front();
          in_tdata  <= {nxt.seed, nxt.value};
          in_tuser  <= nxt.action;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor: compares each beat with the oldest expectation
  always @(posedge clk) begin : check_results
    bag_result_t want;
    int          rx_idle;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          if (err_count < 10)
            $display("unexpected result beat: status %0d value %h count %0d",
                     out_tuser, out_tdata[31:0], out_tdata[42:32]);
          err_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_tuser !== want.status || out_tdata[31:0] !== want.picked ||
              out_tdata[42:32] !== want.count) begin
            if (err_count < 10)
              $display("mismatch: expected status %0d value %h count %0d, got %0d %h %0d",
                       want.status, want.picked, want.count,
                       out_tuser, out_tdata[31:0], out_tdata[42:32]);
            err_count++;
          end
          if (want.status == srbag_pkg::ST_EMPTY) n_empty++;
          if (want.status == srbag_pkg::ST_FULL) n_full++;
          if (int'(want.count) > peak_count) peak_count = want.count;
        end
      end
      rx_idle = (phase == 0) ? 61 : (phase == 1) ? 37 : 0;
      out_tready <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin : stall_watch
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_MAX) begin
        $display("timeout: no beat for %0d cycles", idle_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int n_rand;
    int bias;
    int len;
    int pick;
    int add_lim;
    int del_lim;
    logic [srbag_pkg::ACT_W-1:0] act;

    // directed: empty bag, edge values and seeds, last-slot delete
    queue_op(srbag_pkg::ACT_CLR, '0, '0, 1'b0);
    queue_op(srbag_pkg::ACT_SEL, '0, '1, 1'b0);
    queue_op(srbag_pkg::ACT_DEL, '1, '0, 1'b0);
    queue_op(srbag_pkg::ACT_ADD, 32'h0000_0000, '1, 1'b0);
    queue_op(srbag_pkg::ACT_ADD, 32'hffff_ffff, '0, 1'b0);
    queue_op(srbag_pkg::ACT_ADD, 32'h5a5a_5a5a, '0, 1'b0);
    queue_op(srbag_pkg::ACT_ADD, 32'ha5a5_a5a5, '0, 1'b0);
    queue_op(srbag_pkg::ACT_SEL, '0, '0, 1'b0);
    queue_op(srbag_pkg::ACT_SEL, '0, '1, 1'b0);
    queue_op(srbag_pkg::ACT_SEL, '0, 64'd3, 1'b0);
    queue_op(srbag_pkg::ACT_SEL, '0, 64'd4, 1'b0);
    queue_op(srbag_pkg::ACT_DEL, '0, 64'd3, 1'b0);
    queue_op(srbag_pkg::ACT_DEL, '0, 64'd0, 1'b0);
    queue_op(srbag_pkg::ACT_SEL, '0, 64'd1, 1'b0);
    queue_op(srbag_pkg::ACT_SEL, '0, 64'd0, 1'b0);
    queue_op(srbag_pkg::ACT_CLR, '1, '1, 1'b0);
    queue_op(srbag_pkg::ACT_SEL, '0, 64'd7, 1'b0);
    queue_op(srbag_pkg::ACT_ADD, 32'h0000_0001, '0, 1'b0);
    queue_op(srbag_pkg::ACT_DEL, '0, '1, 1'b0);
    queue_op(srbag_pkg::ACT_DEL, '0, '1, 1'b0);

    // fill to capacity, then hit the full bag from every side
    for (int i = 0; i < srbag_pkg::DEPTH_DEF; i++)
      queue_op(srbag_pkg::ACT_ADD, rand_value(), rand_seed(0), i == 0);
    queue_op(srbag_pkg::ACT_ADD, 32'hffff_ffff, '1, 1'b0);
    queue_op(srbag_pkg::ACT_ADD, 32'h0000_0000, '0, 1'b0);
    queue_op(srbag_pkg::ACT_SEL, '0, '1, 1'b0);
    queue_op(srbag_pkg::ACT_SEL, '0, 64'd1023, 1'b0);
    queue_op(srbag_pkg::ACT_SEL, '0, 64'd1024, 1'b0);
    queue_op(srbag_pkg::ACT_DEL, '0, '1, 1'b0);
    queue_op(srbag_pkg::ACT_ADD, rand_value(), '0, 1'b0);
    queue_op(srbag_pkg::ACT_ADD, rand_value(), '0, 1'b0);
    for (int i = 0; i < 4; i++)
      queue_op(srbag_pkg::ACT_SEL, '0, rand_seed(gen_count), 1'b0);
    queue_op(srbag_pkg::ACT_CLR, '0, '0, 1'b1);

    // random bursts that grow, shrink or hold the bag
    n_rand = 0;
    while (n_rand < RAND_OPS) begin
      bias = $urandom_range(0, 2);
      len  = $urandom_range(20, 80);
      case (bias)
        0:       begin add_lim = 60; del_lim = 75; end
        1:       begin add_lim = 20; del_lim = 65; end
        default: begin add_lim = 35; del_lim = 70; end
      endcase
      for (int j = 0; j < len && n_rand < RAND_OPS; j++) begin
        pick = $urandom_range(0, 99);
        if (pick < add_lim)      act = srbag_pkg::ACT_ADD;
        else if (pick < del_lim) act = srbag_pkg::ACT_DEL;
        else if (pick < 98)      act = srbag_pkg::ACT_SEL;
        else                     act = srbag_pkg::ACT_CLR;
        // mostly refill an empty bag, but keep some empty-bag actions
        if (gen_count == 0 && act != srbag_pkg::ACT_ADD && $urandom_range(0, 3) != 0)
          act = srbag_pkg::ACT_ADD;
        queue_op(act, rand_value(), rand_seed(gen_count), $urandom_range(0, 59) == 0);
        n_rand++;
      end
    end
    total_ops = op_q.size();

    // single reset at the start
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // wait for all actions to go in and all results to come back
    while (op_q.size() != 0 || in_tvalid || expected_q.size() != 0)
      @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("covered %0d adds, %0d deletes, %0d selects, %0d clears",
             n_add, n_del, n_sel, n_clr);
    $display("results: %0d empty, %0d full, peak count %0d, %0d errors",
             n_empty, n_full, peak_count, err_count);
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
